FILE: rtl/core/smar_pkg.sv
// Shared types and constants for the stick menu auto-repeat block.
package smar_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NAV_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd3;

  // Register reset values
  localparam logic        RST_NAV_ENABLE = 1'b1;
  localparam logic [14:0] RST_DEADZONE   = 15'd6553;
  localparam logic [15:0] RST_INIT_DELAY = 16'd300;
  localparam logic [15:0] RST_REPEAT     = 16'd150;

  // Direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;
  localparam int unsigned NUM_DIRS = 4;

  typedef struct packed {
    logic               menu_open;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic        [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  direction;
    logic        pressed;
    logic [31:0] event_time_ms;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] initial_delay_ms;
    logic [15:0] repeat_ms;
  } timing_t;

endpackage

FILE: rtl/core/stick_menu_auto_repeat.sv
// Top level of the stick menu auto-repeat block.
// One input transaction per frame tick carries both stick axes, the tick time and the
// menu-open flag. Each direction beyond the deadzone fires a press and a release event
// on first activation, then again whenever its timer expires (initial delay, then the
// repeat period); all events of a tick share its time stamp and the final one has last
// set. The tick is evaluated in the cycle it is accepted; its events are then sent one
// per cycle while the output is not stalled, from an event buffer through a single
// output register. A tick that fires nothing never enters the buffer; one that fires a
// single direction yields two events, and one that fires a vertical and a horizontal
// direction four. The next tick is accepted in the cycle the buffer hands its final
// event to the output register, which needs that register empty or not stalled.
// Write configuration only while no events are pending.
module stick_menu_auto_repeat (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  smar_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output smar_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smar_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smar_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import smar_pkg::*;

  // Configuration registers
  logic        nav_enable_r;
  logic [14:0] deadzone_r;
  timing_t     timing_r;

  // Event buffer: first and second firing direction of the held tick
  logic        buf_valid_r, buf_valid_nxt;
  logic [1:0]  buf_idx_r, buf_idx_nxt;
  logic        buf_four_r, buf_four_nxt;
  logic [1:0]  dir_a_r, dir_a_nxt;
  logic [1:0]  dir_b_r, dir_b_nxt;
  logic [31:0] buf_time_r, buf_time_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 upd;
  logic                 out_load;
  logic                 buf_last;
  logic signed [16:0]   sx_s, sy_s, dz_s, ndz_s;
  logic [NUM_DIRS-1:0]  active;
  logic [NUM_DIRS-1:0]  fire;
  logic                 fire_v, fire_h;
  logic [1:0]           dir_v, dir_h;
  out_t                 ev;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nav_enable_r              <= RST_NAV_ENABLE;
      deadzone_r                <= RST_DEADZONE;
      timing_r.initial_delay_ms <= RST_INIT_DELAY;
      timing_r.repeat_ms        <= RST_REPEAT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NAV_ENABLE: nav_enable_r              <= cfg_data[0];
        CFG_DEADZONE:   deadzone_r                <= cfg_data[14:0];
        CFG_INIT_DELAY: timing_r.initial_delay_ms <= cfg_data;
        CFG_REPEAT:     timing_r.repeat_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Buffer hands its final event over this cycle, or is empty: take a new tick
  assign out_load  = buf_valid_r & (~out_valid_r | ~out_stall);
  assign buf_last  = buf_four_r ? (buf_idx_r == 2'd3) : (buf_idx_r == 2'd1);
  assign in_stall  = buf_valid_r & ~(out_load & buf_last);
  assign in_accept = in_valid & ~in_stall;
  // Closed menu or disabled navigation leaves all timers untouched
  assign upd       = in_accept & in_data.menu_open & nav_enable_r;

  // Deadzone test in 17-bit signed so the full-scale case needs no special handling
  assign sx_s  = {in_data.stick_x[15], in_data.stick_x};
  assign sy_s  = {in_data.stick_y[15], in_data.stick_y};
  assign dz_s  = {2'b00, deadzone_r};
  assign ndz_s = -dz_s;

  assign active[DIR_UP]    = sy_s < ndz_s;
  assign active[DIR_DOWN]  = sy_s > dz_s;
  assign active[DIR_LEFT]  = sx_s < ndz_s;
  assign active[DIR_RIGHT] = sx_s > dz_s;

  for (genvar d = 0; d < NUM_DIRS; d++) begin : g_dir
    smar_dir u_dir (
      .clk    (clk),
      .rst_n  (rst_n),
      .upd    (upd),
      .active (active[d]),
      .now_ms (in_data.now_ms),
      .timing (timing_r),
      .fire   (fire[d])
    );
  end

  // Up and down exclude each other, as do left and right
  assign fire_v = fire[DIR_UP] | fire[DIR_DOWN];
  assign fire_h = fire[DIR_LEFT] | fire[DIR_RIGHT];
  assign dir_v  = fire[DIR_DOWN] ? DIR_DOWN : DIR_UP;
  assign dir_h  = fire[DIR_RIGHT] ? DIR_RIGHT : DIR_LEFT;

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    buf_idx_nxt   = buf_idx_r;
    buf_four_nxt  = buf_four_r;
    dir_a_nxt     = dir_a_r;
    dir_b_nxt     = dir_b_r;
    buf_time_nxt  = buf_time_r;
    if (upd && (fire_v || fire_h)) begin
      // Load the tick: vertical events first, then horizontal
      buf_valid_nxt = 1'b1;
      buf_idx_nxt   = 2'd0;
      buf_four_nxt  = fire_v & fire_h;
      dir_a_nxt     = fire_v ? dir_v : dir_h;
      dir_b_nxt     = dir_h;
      buf_time_nxt  = in_data.now_ms;
    end else if (out_load) begin
      if (buf_last) begin
        buf_valid_nxt = 1'b0;
      end else begin
        buf_idx_nxt = buf_idx_r + 2'd1;
      end
    end
  end

  // Current event of the buffer: press on even steps, release on odd ones
  always_comb begin
    ev.direction     = buf_idx_r[1] ? dir_b_r : dir_a_r;
    ev.pressed       = ~buf_idx_r[0];
    ev.event_time_ms = buf_time_r;
    ev.last          = buf_last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = ev;
    end else if (!out_stall) begin
      // Drop the transaction once it is taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      buf_idx_r   <= 2'd0;
      buf_four_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      buf_idx_r   <= buf_idx_nxt;
      buf_four_r  <= buf_four_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_a_r    <= dir_a_nxt;
    dir_b_r    <= dir_b_nxt;
    buf_time_r <= buf_time_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/smar_dir.sv
// Repeat timer for one direction: armed flag, expiry time and fire decision.
module smar_dir (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic              active,
  input  logic [31:0]       now_ms,
  input  smar_pkg::timing_t timing,
  output logic              fire
);
  import smar_pkg::*;

  logic        armed_r, armed_nxt;
  logic [31:0] next_fire_r, next_fire_nxt;
  logic [31:0] diff;
  logic        expired;
  logic [15:0] delay;

  // Wrap-safe expiry: difference in the lower half of the 32-bit circle
  assign diff    = now_ms - next_fire_r;
  assign expired = ~diff[31];
  assign fire    = active & (~armed_r | expired);
  assign delay   = armed_r ? timing.repeat_ms : timing.initial_delay_ms;

  always_comb begin
    armed_nxt     = armed_r;
    next_fire_nxt = next_fire_r;
    if (upd) begin
      if (!active) begin
        armed_nxt = 1'b0;
      end else if (fire) begin
        armed_nxt     = 1'b1;
        next_fire_nxt = now_ms + {16'd0, delay};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_fire_r <= next_fire_nxt;
  end

endmodule

FILE: rtl/core/smar_checker.sv
// Port-level checks for the stick menu auto-repeat block, bound to the top level.
module smar_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input smar_pkg::out_t out_data
);
  import smar_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A press always has its release still to come
  a_press_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pressed |-> !out_data.last)
    else $error("press marked as last event");

  // A taken press is followed at once by its release, same direction and time
  a_press_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.pressed |=>
      out_valid && !out_data.pressed &&
      out_data.direction == $past(out_data.direction) &&
      out_data.event_time_ms == $past(out_data.event_time_ms))
    else $error("press not followed by matching release");

  // A press waiting at the output means its release is pending: no new tick
  a_stall_on_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && out_data.pressed |-> in_stall)
    else $error("tick accepted while a release was pending");

endmodule

bind stick_menu_auto_repeat smar_checker u_smar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: bench/tb_stick_menu_auto_repeat.sv
`timescale 1ns / 1ps
// Self-checking bench for the stick menu auto-repeat block: directed and random ticks.

module tb_stick_menu_auto_repeat;
  import smar_pkg::*;

  class key_event_scoreboard;
    logic        nav_on;
    logic [14:0] dz;
    logic [15:0] first_delay;
    logic [15:0] repeat_gap;
    logic [31:0] fire_at [NUM_DIRS];
    logic        armed [NUM_DIRS];
    out_t        due_events [$];
    int          errors;

    function new();
      nav_on      = RST_NAV_ENABLE;
      dz          = RST_DEADZONE;
      first_delay = RST_INIT_DELAY;
      repeat_gap  = RST_REPEAT;
      for (int i = 0; i < NUM_DIRS; i++) begin
        fire_at[i] = '0;
        armed[i]   = 1'b0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_NAV_ENABLE: nav_on      = val[0];
        CFG_DEADZONE:   dz          = val[14:0];
        CFG_INIT_DELAY: first_delay = val;
        CFG_REPEAT:     repeat_gap  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    // Work out the press/release events one accepted tick causes.
    function void note_tick(in_t t);
      logic        active [NUM_DIRS];
      out_t        ev [4];
      int          n;
      int          sx;
      int          sy;
      int          lim;
      logic        fire;
      logic [31:0] gap;
      n = 0;
      if (!t.menu_open || !nav_on) return;
      sx  = $signed(t.stick_x);
      sy  = $signed(t.stick_y);
      lim = int'(dz);
      active[DIR_UP]    = sy < -lim;
      active[DIR_DOWN]  = sy > lim;
      active[DIR_LEFT]  = sx < -lim;
      active[DIR_RIGHT] = sx > lim;
      for (int i = 0; i < NUM_DIRS; i++) begin
        fire = 1'b0;
        if (!active[i]) begin
          armed[i]   = 1'b0;
          fire_at[i] = '0;
        end else if (!armed[i]) begin
          fire       = 1'b1;
          armed[i]   = 1'b1;
          fire_at[i] = t.now_ms + {16'd0, first_delay};
        end else begin
          gap = t.now_ms - fire_at[i];
          if (!gap[31]) begin
            fire       = 1'b1;
            fire_at[i] = t.now_ms + {16'd0, repeat_gap};
          end
        end
        if (fire) begin
          ev[n].direction     = i[1:0];
          ev[n].pressed       = 1'b1;
          ev[n].event_time_ms = t.now_ms;
          ev[n].last          = 1'b0;
          ev[n+1]             = ev[n];
          ev[n+1].pressed     = 1'b0;
          n += 2;
        end
      end
      if (n > 0) ev[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) due_events.push_back(ev[k]);
    endfunction

    function void check_event(out_t got);
      out_t want;
      logic bad;
      if (due_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual dir %0d pressed %0b",
                 $time, got.direction, got.pressed);
        $display("%0t: unexpected event, actual time %h last %0b",
                 $time, got.event_time_ms, got.last);
        errors++;
        return;
      end
      want = due_events.pop_front();
      bad  = 1'b0;
      if (got.direction !== want.direction) begin
        $display("%0t: direction mismatch, expected %0d, actual %0d",
                 $time, want.direction, got.direction);
        bad = 1'b1;
      end
      if (got.pressed !== want.pressed) begin
        $display("%0t: pressed mismatch, expected %0b, actual %0b",
                 $time, want.pressed, got.pressed);
        bad = 1'b1;
      end
      if (got.event_time_ms !== want.event_time_ms) begin
        $display("%0t: event_time_ms mismatch, expected %h, actual %h",
                 $time, want.event_time_ms, got.event_time_ms);
        bad = 1'b1;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %0b, actual %0b",
                 $time, want.last, got.last);
        bad = 1'b1;
      end
      if (bad) errors++;
    endfunction
  endclass

  // Cycles to let a tick that fires nothing clear the block before idle-only actions.
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 300000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  key_event_scoreboard sb;
  logic [31:0]         clock_ms;
  bit                  idle_on    = 1'b1;
  int                  stall_left = 0;
  int                  cycles     = 0;

  stick_menu_auto_repeat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bail out if the block hangs; the limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the result channel in short random bursts; hold it open once idling is off.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sample every handshake on the edge it completes: register writes, accepted
  // ticks and accepted events, in that order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_tick(in_data);
      if (out_valid && !out_stall) sb.check_event(out_data);
    end
  end

  // Present one tick and hold it until accepted. Valid is left high so a following
  // tick goes out back to back; an idle burst drops it first.
  task automatic send_tick(input logic open, input int x, input int y, input logic [31:0] now);
    in_t t;
    t.menu_open = open;
    t.stick_x   = x[15:0];
    t.stick_y   = y[15:0];
    t.now_ms    = now;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all four registers; call only with the block idle.
  task automatic program_regs(input logic [15:0] nav, input logic [15:0] dzone,
                              input logic [15:0] dly, input logic [15:0] rep);
    put_reg(CFG_NAV_ENABLE, nav);
    put_reg(CFG_DEADZONE, dzone);
    put_reg(CFG_INIT_DELAY, dly);
    put_reg(CFG_REPEAT, rep);
    cfg_valid <= 1'b0;
  endtask

  // Stop ticks, wait for every expected event, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pick an axis value around the current deadzone: centered, inside, beyond on
  // either side, right at the threshold, or anything at all.
  function automatic int pick_axis();
    int d;
    d = int'(sb.dz);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return int'($urandom_range(0, 2 * d)) - d;
      2: begin
        if (d == 32767) return -32768;
        return int'($urandom_range(d + 1, 32767));
      end
      3: return -int'($urandom_range(d + 1, 32768));
      4: begin
        case ($urandom_range(0, 3))
          0: return d;
          1: return d + 1;
          2: return -d;
          default: return -(d + 1);
        endcase
      end
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Mostly held stick gestures over advancing time, so timers get to expire;
  // mixed with stray ticks, closed-menu ticks and jumps of the time counter.
  task automatic run_random(input int n, input int step_max);
    int done;
    int len;
    int x;
    int y;
    logic open;
    done = 0;
    while (done < n) begin
      len = $urandom_range(2, 24);
      if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
      x = pick_axis();
      y = pick_axis();
      for (int k = 0; k < len && done < n; k++) begin
        clock_ms += $urandom_range(0, step_max);
        open = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 9) == 0) send_tick(open, pick_axis(), pick_axis(), clock_ms);
        else send_tick(open, x, y, clock_ms);
        if (open) done++;
      end
    end
  endtask

  initial begin
    sb = new();
    clock_ms = 32'd1000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings. Closed menu fires nothing.
    send_tick(1'b0, 0, -32768, 32'd1000);
    // Up and right fire together, then repeat exactly at expiry.
    send_tick(1'b1, 32767, -32768, 32'd1000);
    send_tick(1'b1, 32767, -32768, 32'd1100);
    send_tick(1'b1, 32767, -32768, 32'd1300);
    send_tick(1'b1, 32767, -32768, 32'd1449);
    send_tick(1'b1, 32767, -32768, 32'd1450);
    // Exactly at the deadzone is inactive; one past it is active.
    send_tick(1'b1, 6553, -6553, 32'd1460);
    send_tick(1'b1, 6554, -6554, 32'd1470);
    send_tick(1'b1, -6554, 6554, 32'd1480);
    // Closed menu keeps the timers; the next open tick repeats.
    send_tick(1'b0, 0, 0, 32'd9000);
    send_tick(1'b1, -6554, 6554, 32'd9000);
    send_tick(1'b1, -32768, 0, 32'd9010);
    send_tick(1'b1, -32768, 0, 32'd9150);
    // Timer armed just before the time counter wraps.
    send_tick(1'b1, 0, 0, 32'hFFFF_FF00);
    send_tick(1'b1, 0, 32767, 32'hFFFF_FF00);
    send_tick(1'b1, 0, 32767, 32'h0000_002B);
    send_tick(1'b1, 0, 32767, 32'h0000_002C);
    run_random(80, 40);

    // Full-scale deadzone with zero delays: only -32768 counts, every tick repeats.
    drain();
    program_regs(16'h0001, 16'h7FFF, 16'h0000, 16'h0000);
    send_tick(1'b1, -32768, -32768, 32'd5000);
    send_tick(1'b1, -32768, -32768, 32'd5000);
    send_tick(1'b1, 32767, 32767, 32'd5001);
    send_tick(1'b1, -32767, -32768, 32'd5002);
    run_random(60, 8);

    // Navigation off: ticks are dropped and the timers stay as they are.
    drain();
    program_regs(16'hFFFE, 16'h0000, 16'hFFFF, 16'hFFFF);
    run_random(20, 40);

    // Zero deadzone and longest delays.
    drain();
    program_regs(16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1, 1, 0, 32'd100);
    send_tick(1'b1, 0, 0, 32'd101);
    send_tick(1'b1, -1, 1, 32'd102);
    send_tick(1'b1, -1, 1, 32'd102 + 32'd65534);
    send_tick(1'b1, -1, 1, 32'd102 + 32'd65535);
    clock_ms = 32'd70000;
    run_random(60, 40);

    // Random settings; the unused top bit of the deadzone data is random too.
    drain();
    program_regs({15'($urandom_range(0, 32767)), 1'b1}, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 400)), 16'($urandom_range(0, 200)));
    run_random(100, 40);

    // Last stretch at full rate on both sides.
    drain();
    program_regs(16'h0001, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 400)), 16'($urandom_range(0, 200)));
    idle_on = 1'b0;
    run_random(100, 30);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/smar_pkg.sv
rtl/core/smar_dir.sv
rtl/core/stick_menu_auto_repeat.sv
rtl/core/smar_checker.sv
bench/tb_stick_menu_auto_repeat.sv
